[hdl/dhcp_lease_table_assert.svh]
// Assertion macros for the lease table.
`ifndef DHCP_LEASE_TABLE_ASSERT_SVH
`define DHCP_LEASE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define DLT_ASSERT_IMPL(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define DLT_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define DLT_ASSERT_IMPL(label, clk, rst, a, b, msg)
`define DLT_ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

[hdl/dlt_pkg.sv]
`timescale 1ns / 1ps
package dlt_pkg;
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [31:0] HOLD_SECONDS = 32'd42;
   localparam logic [31:0] LEASE_RESET = 32'd600;
   localparam logic [6:0] COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      ACT_DISCOVER = 2'd0,
      ACT_REQUEST  = 2'd1,
      ACT_OTHER    = 2'd2,
      ACT_TICK     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_OFFER = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_NAK   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_SERVER = 2'd0,
      REG_START  = 2'd1,
      REG_COUNT  = 2'd2,
      REG_LEASE  = 2'd3
   } reg_type;

   typedef struct packed {
      logic [47:0] mac;
      logic [31:0] expiry;
   } entry_type;
endpackage

[hdl/dhcp_lease_table.sv]
`timescale 1ns / 1ps
// Lease table: a ring of TABLE_DEPTH cells that rotates one entry per cycle while busy,
// unless the last write step is held. Discover and request raise the result after a
// decide pass and a write pass around the ring; tick and other raise no result.
// One item at a time: req_stall is high while a discover/request runs; the last
// write step holds while an earlier result still waits on rsp_stall.
// Synchronous reset empties all entries, zeroes the clock, loads register defaults.
module dhcp_lease_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [47:0] req_client_mac,
   input  logic [31:0] req_client_address,
   input  logic [31:0] req_requested_address,
   input  logic [31:0] req_server_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_reply_kind,
   output logic [31:0] rsp_your_address,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import dlt_pkg::*;
`include "dhcp_lease_table_assert.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   // configuration
   logic [31:0] server_ff, start_ff, lease_ff;
   logic [6:0]  count_ff;
   logic [31:0] now_ff;

   // operation control
   state_type       state_ff;
   logic            is_disc_ff;
   logic [47:0]     mac_ff;
   logic [31:0]     ip_ff;
   logic            req_ok_ff;
   logic [31:0]     off_ff;
   logic [31:0]     wr_exp_ff;
   logic [IDX_W-1:0] step_ff;
   logic            found_ff, have_exp_ff, hit_ff;
   logic [IDX_W-1:0] pick_ff, exp_idx_ff;

   logic        rsp_valid_ff;
   kind_type    kind_ff;
   logic [31:0] addr_ff;

   // ring of cells; cell 0 is the head the controller watches
   entry_type ring_out [TABLE_DEPTH];
   entry_type ring_in  [TABLE_DEPTH];
   entry_type head_back;
   logic      shift;
   logic      write_last;
   logic      hold_done;

   // Hold the ring at the last write step while the previous result still waits.
   assign write_last = (state_ff == ST_WRITE) && (step_ff == LAST_IDX);
   assign hold_done  = write_last && rsp_valid_ff && rsp_stall;
   assign shift      = (state_ff != ST_IDLE) && !hold_done;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         if (g == TABLE_DEPTH - 1) begin : g_tail
            assign ring_in[g] = head_back;
         end else begin : g_mid
            assign ring_in[g] = ring_out[g+1];
         end
         dlt_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .entry_in  (ring_in[g]),
            .entry_out (ring_out[g])
         );
      end
   endgenerate

   entry_type head;
   logic      head_live, head_match, head_expired;
   logic      do_write;
   assign head         = ring_out[0];
   assign head_live    = {{(32-IDX_W){1'b0}}, step_ff} < {25'd0, count_ff};
   assign head_match   = (head.mac == mac_ff) || (head.mac == 48'd0);
   assign head_expired = head.expiry < now_ff;
   assign do_write     = is_disc_ff ? (found_ff || have_exp_ff) : hit_ff;

   // Feed the head entry back to the tail, updating the chosen entry in the write pass.
   always_comb begin
      head_back = head;
      if (state_ff == ST_WRITE && do_write && step_ff == pick_ff) begin
         head_back.expiry = wr_exp_ff;
         if (is_disc_ff) begin
            head_back.mac = mac_ff;
         end
      end
   end

   // saturating adds
   logic [32:0] hold_sum, lease_sum, tick_sum;
   assign hold_sum  = {1'b0, now_ff} + {1'b0, HOLD_SECONDS};
   assign lease_sum = {1'b0, now_ff} + {1'b0, lease_ff};
   assign tick_sum  = {1'b0, now_ff} + 33'd1;

   logic [31:0] ip_sel;
   assign ip_sel = (req_client_address != 32'd0) ? req_client_address : req_requested_address;

   logic take;
   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_ff    <= '0;
         start_ff     <= '0;
         count_ff     <= COUNT_RESET;
         lease_ff     <= LEASE_RESET;
         now_ff       <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (reg_type'(csr_index))
               REG_SERVER: server_ff <= csr_data;
               REG_START:  start_ff  <= csr_data;
               REG_COUNT:  count_ff  <= csr_data[6:0];
               REG_LEASE:  lease_ff  <= csr_data;
               default:    ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && !write_last) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  mac_ff      <= req_client_mac;
                  ip_ff       <= ip_sel;
                  off_ff      <= ip_sel - start_ff;
                  req_ok_ff   <= ((req_server_id == 32'd0) || (req_server_id == server_ff))
                                 && (ip_sel != 32'd0);
                  step_ff     <= '0;
                  found_ff    <= 1'b0;
                  have_exp_ff <= 1'b0;
                  hit_ff      <= 1'b0;
                  pick_ff     <= '0;
                  exp_idx_ff  <= '0;
                  unique case (action_type'(req_action))
                     ACT_DISCOVER: begin
                        is_disc_ff <= 1'b1;
                        wr_exp_ff  <= hold_sum[32] ? 32'hFFFF_FFFF : hold_sum[31:0];
                        state_ff   <= ST_SCAN;
                     end
                     ACT_REQUEST: begin
                        is_disc_ff <= 1'b0;
                        wr_exp_ff  <= lease_sum[32] ? 32'hFFFF_FFFF : lease_sum[31:0];
                        state_ff   <= ST_SCAN;
                     end
                     ACT_TICK: begin
                        now_ff <= tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               // decide pass: discover takes first empty or own entry, else last expired; request checks its offset
               if (is_disc_ff) begin
                  if (head_live && !found_ff) begin
                     if (head_match) begin
                        found_ff <= 1'b1;
                        pick_ff  <= step_ff;
                     end else if (head_expired) begin
                        have_exp_ff <= 1'b1;
                        exp_idx_ff  <= step_ff;
                     end
                  end
               end else if (req_ok_ff && off_ff < {25'd0, count_ff}
                            && off_ff < 32'(TABLE_DEPTH)
                            && off_ff[IDX_W-1:0] == step_ff && head.mac == mac_ff) begin
                  hit_ff  <= 1'b1;
                  pick_ff <= step_ff;
               end
               if (step_ff == LAST_IDX) begin
                  if (is_disc_ff && !found_ff && !(head_live && head_match)
                      && !(head_live && head_expired)) begin
                     pick_ff <= exp_idx_ff;
                  end else if (is_disc_ff && !found_ff && !(head_live && head_match)) begin
                     pick_ff <= step_ff;
                  end
                  step_ff  <= '0;
                  state_ff <= ST_WRITE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_WRITE: begin
               if (step_ff == LAST_IDX) begin
                  if (!hold_done) begin
                     state_ff     <= ST_IDLE;
                     rsp_valid_ff <= 1'b1;
                     if (!do_write) begin
                        kind_ff <= KIND_NAK;
                        addr_ff <= '0;
                     end else if (is_disc_ff) begin
                        kind_ff <= KIND_OFFER;
                        addr_ff <= start_ff + {{(32-IDX_W){1'b0}}, pick_ff};
                     end else begin
                        kind_ff <= KIND_ACK;
                        addr_ff <= ip_ff;
                     end
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_kind   = kind_ff;
   assign rsp_your_address = addr_ff;

   `DLT_ASSERT_IMPL(a_busy_stalls, clock, reset, state_ff != ST_IDLE, req_stall, "input taken while busy")
   `DLT_ASSERT_IMPL(a_nak_zero, clock, reset, rsp_valid_ff && kind_ff == KIND_NAK, addr_ff == 32'd0, "NAK with address")
   `DLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(addr_ff), "result dropped")
endmodule

[hdl/dlt_cell.sv]
`timescale 1ns / 1ps
module dlt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  dlt_pkg::entry_type  entry_in,
   output dlt_pkg::entry_type  entry_out
);
   import dlt_pkg::*;

   entry_type entry_ff;

   // Reset empties the entry; shift takes the neighbor's entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;
endmodule
